### src/ucd_pkg.sv
package ucd_pkg;

  localparam int unsigned TableEntries = 256;

  typedef enum logic [0:0] {
    CFG_UTF8_MODE    = 1'b0,
    CFG_UNKNOWN_CHAR = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] LeadInvalid  = 8'hf0;
  localparam logic [7:0] LeadAscii    = 8'h80;
  localparam logic [7:0] LeadThree    = 8'he0;
  localparam logic [1:0] ContTag      = 2'b10;

  typedef struct packed {
    logic [15:0] code_point;
    logic [1:0]  byte_count;
    logic        parse_error;
  } result_t;

  typedef struct packed {
    logic        utf8_mode;
    logic [15:0] unknown_char;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_in;
  } stage_t;

  localparam logic [15:0] CpRom [TableEntries] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0006, 16'h0007,
    16'h0008, 16'h0009, 16'h000a, 16'h000b, 16'h000c, 16'h000d, 16'h000e, 16'h000f,
    16'h00a0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
    16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005a, 16'h005b, 16'h005c, 16'h005d, 16'h005e, 16'h005f,
    16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007a, 16'h007b, 16'h007c, 16'h007d, 16'h007e, 16'h0000,
    16'h20ac, 16'h0000, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
    16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017d, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
    16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h0000, 16'h017e, 16'h0178,
    16'h0000, 16'h00a1, 16'h00a2, 16'h00a3, 16'h00a4, 16'h00a5, 16'h00a6, 16'h00a7,
    16'h00a8, 16'h00a9, 16'h00aa, 16'h00ab, 16'h00ac, 16'h00ad, 16'h00ae, 16'h00af,
    16'h00b0, 16'h00b1, 16'h00b2, 16'h00b3, 16'h00b4, 16'h00b5, 16'h00b6, 16'h00b7,
    16'h00b8, 16'h00b9, 16'h00ba, 16'h00bb, 16'h00bc, 16'h00bd, 16'h00be, 16'h00bf,
    16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h00c4, 16'h00c5, 16'h00c6, 16'h00c7,
    16'h00c8, 16'h00c9, 16'h00ca, 16'h00cb, 16'h00cc, 16'h00cd, 16'h00ce, 16'h00cf,
    16'h00d0, 16'h00d1, 16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h00d6, 16'h00d7,
    16'h00d8, 16'h00d9, 16'h00da, 16'h00db, 16'h00dc, 16'h00dd, 16'h00de, 16'h00df,
    16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h00e4, 16'h00e5, 16'h00e6, 16'h00e7,
    16'h00e8, 16'h00e9, 16'h00ea, 16'h00eb, 16'h00ec, 16'h00ed, 16'h00ee, 16'h00ef,
    16'h00f0, 16'h00f1, 16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h00f6, 16'h00f7,
    16'h00f8, 16'h00f9, 16'h00fa, 16'h00fb, 16'h00fc, 16'h00fd, 16'h00fe, 16'h00ff
  };

endpackage

### src/ucd_if.sv
interface ucd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface ucd_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic [1:0]  byte_count;
  logic        parse_error;

  modport source (output valid, output code_point, output byte_count,
                  output parse_error, input ready);
  modport sink   (input valid, input code_point, input byte_count,
                  input parse_error, output ready);
endinterface

### src/utf8_or_codepage_char_decoder.sv
// UTF-8 / code-page character decoder.
// in_if carries one raw byte word per handshake; out_if carries one UCS-2
// character word (code_point, byte_count, parse_error) per completed character.
// Bytes that open or continue a multi-byte sequence give no output word.
// cfg_we writes register cfg_index (utf8_mode, unknown_char) from cfg_data;
// write only while no word is in flight.
// A byte accepted into the input register shows its character at out_if once
// it has moved on into the result register. Throughput is one byte per cycle
// while out_if does not stall; the decode state and the code-page table
// lookup sit in the single logic stage between the two registers.
// Reset (rst_n low, synchronous) empties both registers, clears any pending
// sequence, selects UTF-8 mode and sets unknown_char to zero.
// When out_if stalls, the result register holds its word; one more byte is
// taken into the input register, then in_if.ready drops until out_if moves.
module utf8_or_codepage_char_decoder (
  input  logic               clk,
  input  logic               rst_n,
  ucd_byte_if.sink           in_if,
  ucd_char_if.source         out_if,
  input  logic               cfg_we,
  input  ucd_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);

  ucd_pkg::cfg_t    cfg_r;
  ucd_pkg::stage_t  stage;
  ucd_pkg::result_t res;
  ucd_pkg::result_t out_res;
  logic             emit;
  logic             can_load;
  logic             advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.utf8_mode    <= 1'b1;
      cfg_r.unknown_char <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ucd_pkg::CFG_UTF8_MODE:    cfg_r.utf8_mode    <= cfg_data[0];
        ucd_pkg::CFG_UNKNOWN_CHAR: cfg_r.unknown_char <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = stage.valid && can_load;

  ucd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_byte  (in_if.byte_in),
    .in_ready (in_if.ready),
    .advance  (advance),
    .stage    (stage)
  );

  ucd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (stage.byte_in),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (res)
  );

  ucd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign out_if.code_point  = out_res.code_point;
  assign out_if.byte_count  = out_res.byte_count;
  assign out_if.parse_error = out_res.parse_error;

endmodule

### src/ucd_in_reg.sv
module ucd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            advance,
  output ucd_pkg::stage_t stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.byte_in = byte_r;

endmodule

### src/ucd_core.sv
module ucd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       byte_in,
  input  ucd_pkg::cfg_t    cfg,
  output logic             emit,
  output ucd_pkg::result_t res
);

  logic [1:0]  pending_r, pending_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [11:0] partial_r, partial_nxt;
  logic [15:0] table_cp;

  assign table_cp = ucd_pkg::CpRom[byte_in];

  always_comb begin
    pending_nxt     = pending_r;
    seen_nxt        = seen_r;
    partial_nxt     = partial_r;
    emit            = 1'b0;
    res.code_point  = '0;
    res.byte_count  = 2'd1;
    res.parse_error = 1'b0;
    if (!cfg.utf8_mode) begin
      pending_nxt    = '0;
      seen_nxt       = '0;
      partial_nxt    = '0;
      emit           = 1'b1;
      res.code_point = (table_cp == 16'h0000) ? cfg.unknown_char : table_cp;
    end else if (pending_r == 2'd0) begin
      if (byte_in >= ucd_pkg::LeadInvalid) begin
        emit            = 1'b1;
        res.parse_error = 1'b1;
      end else if (byte_in < ucd_pkg::LeadAscii) begin
        emit           = 1'b1;
        res.code_point = {8'h00, byte_in};
      end else begin
        seen_nxt = 2'd1;
        if (byte_in < ucd_pkg::LeadThree) begin
          pending_nxt = 2'd1;
          partial_nxt = {7'd0, byte_in[4:0]};
        end else begin
          pending_nxt = 2'd2;
          partial_nxt = {8'd0, byte_in[3:0]};
        end
      end
    end else if (byte_in[7:6] != ucd_pkg::ContTag) begin
      emit            = 1'b1;
      res.parse_error = 1'b1;
      res.byte_count  = seen_r + 2'd1;
      pending_nxt     = '0;
      seen_nxt        = '0;
      partial_nxt     = '0;
    end else if (pending_r == 2'd1) begin
      emit           = 1'b1;
      res.code_point = {partial_r[9:0], byte_in[5:0]};
      res.byte_count = seen_r + 2'd1;
      pending_nxt    = '0;
      seen_nxt       = '0;
      partial_nxt    = '0;
    end else begin
      pending_nxt = pending_r - 2'd1;
      seen_nxt    = seen_r + 2'd1;
      partial_nxt = {partial_r[5:0], byte_in[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      seen_r    <= '0;
      partial_r <= '0;
    end else if (advance) begin
      pending_r <= pending_nxt;
      seen_r    <= seen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

### src/ucd_out_reg.sv
module ucd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ucd_pkg::result_t res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output ucd_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  ucd_pkg::result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
